// ===== sv/hrsp_pkg.sv =====
package hrsp_pkg;

  localparam int TICK_COUNT_BITS_DEF = 16;

  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 32;

  localparam logic [16:0] FULL_CIRCLE = 17'd36000;
  localparam logic [15:0] HALF_CIRCLE = 16'd18000;
  localparam logic [15:0] TOLERANCE = 16'd150;
  localparam logic [15:0] NEAR_FULL = 16'd35850;
  localparam logic [15:0] Q15_MAX = 16'd32767;

  typedef enum logic [2:0] {
    CFG_TARGET_ANGLE   = 3'd0,
    CFG_ABSOLUTE_MODE  = 3'd1,
    CFG_MIN_SPEED      = 3'd2,
    CFG_RAMP_DOWN_ZONE = 3'd3,
    CFG_RAMP_UP_TICKS  = 3'd4,
    CFG_TIMEOUT_TICKS  = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WRAP = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic signed [15:0] yaw;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] turn_speed;
    logic               done_res;
    logic               timed_out;
  } out_word_t;

endpackage

// ===== sv/hrsp_mul.sv =====
module hrsp_mul
  import hrsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic        done_o,
  output logic [31:0] prod_o
);

  localparam int CNT_W = $clog2(MUL_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_STEPS - 1);

  logic [15:0]      a_q, a_d;
  logic [31:0]      p_q, p_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [16:0]      sum;

  // add the multiplicand into the upper half when the low bit is set, then shift one bit right
  assign sum = {1'b0, p_q[31:16]} + (p_q[0] ? {1'b0, a_q} : 17'd0);

  always_comb begin
    a_d    = a_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      p_d    = {16'd0, b_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {sum, p_q[15:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ===== sv/hrsp_div.sv =====
module hrsp_div
  import hrsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dvd_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_STEPS - 1);

  logic [15:0]      den_q, den_d;
  logic [15:0]      rem_q, rem_d;
  logic [31:0]      dvd_q, dvd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [16:0]      trial;
  logic             fits;

  // restoring step, quotient bits shift into the dividend register
  assign trial = {rem_q, dvd_q[31]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      den_d  = den_i;
      rem_d  = '0;
      dvd_d  = dvd_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      dvd_d = {dvd_q[30:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q[15:0];

endmodule

// ===== sv/heading_rotate_speed_profile.sv =====
// start word: S_WRAP subtracts 36000 once a cycle to wrap the goal, then S_OUT
// tick word in a speed ramp: 16-step serial multiply then 32-step divide, then S_OUT
// other tick words go to S_OUT; one word at a time, result held in an output register
// next word taken the cycle after the result loads; S_OUT waits while the output stalls
// reset (rst_ni low, asynchronous) gives idle, zero headings and default register values
module heading_rotate_speed_profile
  import hrsp_pkg::*;
#(
  parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o
);

  localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

  logic signed [16:0] target_q;
  logic               abs_mode_q;
  logic [14:0]        min_speed_q;
  logic [14:0]        rdz_q;
  logic [15:0]        rut_q;
  logic [15:0]        tmo_q;

  state_e state_q, state_d;
  logic [15:0] goal_q, goal_d;
  logic [15:0] present_q, present_d;
  logic        cw_q, cw_d;
  logic [TICK_COUNT_BITS-1:0] tick_q, tick_d;
  logic        active_q, active_d;
  logic [17:0] wrap_q, wrap_d;
  logic [15:0] den_q, den_d;
  out_word_t   res_q, res_d;
  out_word_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic               in_acc;
  logic signed [17:0] yaw_s;
  logic [16:0]        yaw_u;
  logic [15:0]        heading;
  logic signed [18:0] goal_s;
  logic [TICK_COUNT_BITS-1:0] tick_inc;
  logic [CW-1:0]      tick_ext;
  logic [16:0]        diff;
  logic [15:0]        diff_abs;
  logic [14:0]        err;
  logic [16:0]        arr_diff;
  logic [15:0]        arr_abs;
  logic               finished;
  logic               timeout;
  logic [15:0]        span;
  logic               ramp_down;
  logic               ramp_up;
  logic               mul_start;
  logic [15:0]        mul_b;
  logic               mul_done;
  logic [31:0]        mul_prod;
  logic               div_done;
  logic [15:0]        div_quo;
  logic [15:0]        speed;
  logic [15:0]        wrap_goal;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // yaw to heading, 0..35999
  assign yaw_s   = 18'(in_data_i.yaw) + 18'sd36000;
  assign yaw_u   = yaw_s[16:0];
  assign heading = (yaw_u >= FULL_CIRCLE) ? 16'(yaw_u - FULL_CIRCLE) : yaw_u[15:0];

  assign goal_s = (abs_mode_q ? 19'(target_q) : 19'(target_q) + $signed({3'b000, heading}))
                  + 19'sd72000;

  assign tick_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
  assign tick_ext = CW'(tick_inc);

  // wrapped error of the heading held before this tick
  assign diff     = {1'b0, present_q} - {1'b0, goal_q};
  assign diff_abs = diff[16] ? 16'(-diff) : diff[15:0];
  assign err      = (diff_abs > HALF_CIRCLE) ? 15'(FULL_CIRCLE - {1'b0, diff_abs})
                                             : diff_abs[14:0];

  assign arr_diff = {1'b0, goal_q} - {1'b0, heading};
  assign arr_abs  = arr_diff[16] ? 16'(-arr_diff) : arr_diff[15:0];
  assign finished = (heading != present_q) && ((arr_abs < TOLERANCE) || (arr_abs > NEAR_FULL));
  assign timeout  = tick_ext >= CW'(tmo_q);

  assign span      = 16'(17'h08000 - {2'b00, min_speed_q});
  assign ramp_down = err < rdz_q;
  assign ramp_up   = tick_ext < CW'(rut_q);
  assign mul_b     = ramp_down ? {1'b0, err} : tick_ext[15:0];
  assign mul_start = in_acc && in_data_i.cmd && active_q && (ramp_down || ramp_up);

  assign speed     = {1'b0, min_speed_q} + div_quo;
  assign wrap_goal = wrap_q[15:0];

  hrsp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (span),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  hrsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done),
    .dvd_i   (mul_prod),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    goal_d      = goal_q;
    present_d   = present_q;
    cw_d        = cw_q;
    tick_d      = tick_q;
    active_d    = active_q;
    wrap_d      = wrap_q;
    den_d       = den_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          if (!in_data_i.cmd) begin
            present_d = heading;
            wrap_d    = goal_s[17:0];
            tick_d    = '0;
            active_d  = 1'b1;
            state_d   = S_WRAP;
          end else if (!active_q) begin
            state_d = S_OUT;
          end else begin
            tick_d          = tick_inc;
            present_d       = heading;
            res_d.done_res  = timeout || finished;
            res_d.timed_out = timeout;
            if (timeout || finished) begin
              active_d = 1'b0;
            end
            if (ramp_down) begin
              den_d   = {1'b0, rdz_q};
              state_d = S_MUL;
            end else if (ramp_up) begin
              den_d   = rut_q;
              state_d = S_MUL;
            end else begin
              res_d.turn_speed = cw_q ? Q15_MAX : 16'(-Q15_MAX);
              state_d          = S_OUT;
            end
          end
        end
      end
      S_WRAP: begin
        if (wrap_q >= 18'(FULL_CIRCLE)) begin
          wrap_d = wrap_q - 18'(FULL_CIRCLE);
        end else begin
          goal_d = wrap_goal;
          if (wrap_goal > present_q) begin
            cw_d = (wrap_goal - present_q) < HALF_CIRCLE;
          end else begin
            cw_d = (present_q - wrap_goal) > HALF_CIRCLE;
          end
          state_d = S_OUT;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.turn_speed = cw_q ? speed : 16'(-speed);
          state_d          = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      abs_mode_q  <= 1'b0;
      min_speed_q <= 15'd8192;
      rdz_q       <= 15'd3000;
      rut_q       <= 16'd25;
      tmo_q       <= 16'd250;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_ANGLE:   target_q    <= $signed(cfg_wdata_i);
        CFG_ABSOLUTE_MODE:  abs_mode_q  <= cfg_wdata_i[0];
        CFG_MIN_SPEED:      min_speed_q <= cfg_wdata_i[14:0];
        CFG_RAMP_DOWN_ZONE: rdz_q       <= cfg_wdata_i[14:0];
        CFG_RAMP_UP_TICKS:  rut_q       <= cfg_wdata_i[15:0];
        CFG_TIMEOUT_TICKS:  tmo_q       <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      goal_q      <= '0;
      present_q   <= '0;
      cw_q        <= 1'b0;
      tick_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      goal_q      <= goal_d;
      present_q   <= present_d;
      cw_q        <= cw_d;
      tick_q      <= tick_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wrap_q <= wrap_d;
    den_q  <= den_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
